// ----- rtl/core/grid_local_minimum_risk_sum_defines.svh -----
// assertion macros used by the checker file
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_DEFINES_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GLMRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define GLMRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/glmrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package glmrs_pkg;

  // field widths
  localparam int SAMPLE_BITS   = 4;
  localparam int COORD_BITS    = 7;
  localparam int RISK_BITS     = 5;
  localparam int ACC_BITS      = 19;
  localparam int CFG_BITS      = 8;
  localparam int RESULTS_MAX   = 3;
  localparam int CNT_BITS      = 2;

  // port widths
  localparam int S_DATA_BITS   = 8;
  localparam int M_DATA_BITS   = 40;
  localparam int ADDR_BITS     = 3;
  localparam int APB_DATA_BITS = 32;

  // register reset value
  localparam logic [CFG_BITS-1:0] DIM_RESET = 8'd100;

  // register index, taken from paddr bit 2
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [RISK_BITS-1:0]   risk_t;
  typedef logic [ACC_BITS-1:0]    acc_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  // where the current sample sits in the frame
  typedef struct packed {
    logic first_row;   // row 0
    logic upper_rows;  // row 0 or 1
    logic first_col;   // column 0
    logic lead_cols;   // column 0 or 1
    logic last_col;
    logic last_row;
  } pos_t;

  // neighbourhood around the current sample
  typedef struct packed {
    sample_t north;      // two rows up, same column
    sample_t west;       // one row up, column to the west
    sample_t centre_up;  // one row up, same column
    sample_t east;       // one row up, column to the east
    sample_t cur0;       // this row, one column back
    sample_t cur1;       // this row, two columns back
  } nbr_t;

  typedef struct packed {
    coord_t cell_col;
    coord_t cell_row;
    logic   is_low;
    risk_t  risk;
    acc_t   risk_total;
    logic   frame_done;
    logic   last_of_item;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/glmrs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glmrs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, a same-edge write to the same word is passed through
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/glmrs_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glmrs_eval (
  input  wire glmrs_pkg::sample_t                         sample,
  input  wire glmrs_pkg::coord_t                          col,
  input  wire glmrs_pkg::coord_t                          row,
  input  wire glmrs_pkg::pos_t                            pos,
  input  wire glmrs_pkg::nbr_t                            nbr,
  input  wire glmrs_pkg::acc_t                            acc,
  output glmrs_pkg::result_t [glmrs_pkg::RESULTS_MAX-1:0] res,
  output glmrs_pkg::cnt_t                                 cnt,
  output glmrs_pkg::acc_t                                 acc_next
);

  import glmrs_pkg::*;

  logic [RESULTS_MAX-1:0] emit_v;
  logic [RESULTS_MAX-1:0] emit_low;
  sample_t                centre [RESULTS_MAX];
  risk_t                  risk   [RESULTS_MAX];
  acc_t                   total  [RESULTS_MAX];
  result_t                emit   [RESULTS_MAX];

  // which cells this sample decides: the one above, the one to the west
  // on the last row, and itself at the end of the last row
  assign emit_v[0] = !pos.first_row;
  assign emit_v[1] = pos.last_row && !pos.first_col;
  assign emit_v[2] = pos.last_row && pos.last_col;

  assign centre[0] = nbr.centre_up;
  assign centre[1] = nbr.cur0;
  assign centre[2] = sample;

  // strict minimum tests, missing neighbours count as higher
  assign emit_low[0] = (pos.upper_rows || (nbr.centre_up < nbr.north)) &&
                       (nbr.centre_up < sample) &&
                       (pos.first_col || (nbr.centre_up < nbr.west)) &&
                       (pos.last_col || (nbr.centre_up < nbr.east));
  assign emit_low[1] = (pos.first_row || (nbr.cur0 < nbr.west)) &&
                       (pos.lead_cols || (nbr.cur0 < nbr.cur1)) &&
                       (nbr.cur0 < sample);
  assign emit_low[2] = (pos.first_row || (sample < nbr.centre_up)) &&
                       (pos.first_col || (sample < nbr.cur0));

  // risk per cell and running frame sum
  always_comb begin
    for (int i = 0; i < RESULTS_MAX; i++) begin
      risk[i] = (emit_v[i] && emit_low[i]) ? (RISK_BITS'(centre[i]) + RISK_BITS'(1)) : '0;
    end
  end

  assign total[0] = acc + ACC_BITS'(risk[0]);
  assign total[1] = total[0] + ACC_BITS'(risk[1]);
  assign total[2] = total[1] + ACC_BITS'(risk[2]);

  // frame end clears the sum for the next frame
  assign acc_next = emit_v[2] ? '0 : total[2];

  // result words before compaction
  always_comb begin
    for (int i = 0; i < RESULTS_MAX; i++) begin
      emit[i].is_low       = emit_low[i];
      emit[i].risk         = risk[i];
      emit[i].risk_total   = total[i];
      emit[i].last_of_item = 1'b0;
    end
    emit[0].cell_col   = col;
    emit[0].cell_row   = row - COORD_BITS'(1);
    emit[0].frame_done = 1'b0;
    emit[1].cell_col   = col - COORD_BITS'(1);
    emit[1].cell_row   = row;
    emit[1].frame_done = 1'b0;
    emit[2].cell_col   = col;
    emit[2].cell_row   = row;
    emit[2].frame_done = 1'b1;
  end

  // pack the live results to the front, in order, and tag the last one
  always_comb begin
    res = '0;
    cnt = '0;
    for (int i = 0; i < RESULTS_MAX; i++) begin
      if (emit_v[i]) begin
        res[cnt] = emit[i];
        cnt      = cnt + CNT_BITS'(1);
      end
    end
    if (cnt != '0) begin
      res[cnt - CNT_BITS'(1)].last_of_item = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/glmrs_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glmrs_outq (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       load,
  input  wire glmrs_pkg::cnt_t                            load_cnt,
  input  wire glmrs_pkg::result_t [glmrs_pkg::RESULTS_MAX-1:0] load_res,
  input  wire logic                                       pop,
  output glmrs_pkg::result_t                              head,
  output glmrs_pkg::cnt_t                                 cnt
);

  import glmrs_pkg::*;

  result_t q [RESULTS_MAX];

  // fill level, loaded only when empty or when the last word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (pop) begin
      cnt <= cnt - CNT_BITS'(1);
    end
  end

  // result words, shifted toward the head as they are taken
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RESULTS_MAX; i++) begin
        q[i] <= load_res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RESULTS_MAX - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
  end

  assign head = q[0];

endmodule

`default_nettype wire

// ----- rtl/core/grid_local_minimum_risk_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake          | word
// ---------+-----------+--------------------+---------------------------------------
// s_       | in        | s_tvalid/s_tready  | tdata: sample
// m_       | out       | m_tvalid/m_tready  | tdata: col,row,is_low,risk,total;
//          |           |                    | tlast: last_of_item, tuser: frame_done
// apb      | in        | psel/penable       | frame_width @0x0, frame_height @0x4
//
// one sample is taken per cycle while the result queue keeps up; it waits in the
// evaluate register, where both line buffer reads land, then its 0 to 3 results
// move to the result queue. rows between the first and the last give one result
// per sample, so the stream runs at one word per cycle while m_tready is high; a
// sample gives at most three results and each result beyond one holds the input
// back, set by the single result port draining the queue. rst clears the
// counters, windows and risk sum; the line buffers are not cleared and are
// written before use.

module grid_local_minimum_risk_sum #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [glmrs_pkg::S_DATA_BITS-1:0]    s_tdata,   // [3:0] sample
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [6:0] cell_col, [13:7] cell_row, [14] is_low, [19:15] risk, [38:20] risk_total
  output logic      [glmrs_pkg::M_DATA_BITS-1:0]    m_tdata,
  output logic                                      m_tlast,
  output logic                                      m_tuser,   // [0] frame_done
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [glmrs_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [glmrs_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [glmrs_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                      pready
);

  import glmrs_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_BITS) ? $clog2(MAX_WIDTH + 1) : CFG_BITS;
  localparam int HW  = ($clog2(MAX_HEIGHT + 1) > CFG_BITS) ? $clog2(MAX_HEIGHT + 1) : CFG_BITS;

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;
  logic                cfg_we;

  logic [CW-1:0]       col_count;
  logic [RW-1:0]       row_count;
  logic [WW:0]         col_inc;
  logic [HW:0]         row_inc;
  logic                last_col;
  logic                last_row;
  logic [CW-1:0]       col_next;
  logic [RW-1:0]       row_next;
  pos_t                pos_in;

  logic                s_fire;
  logic                s1_valid;
  logic                s1_go;
  sample_t             s1_sample;
  logic [CW-1:0]       s1_cidx;
  coord_t              s1_col;
  coord_t              s1_row;
  pos_t                s1_pos;

  sample_t             prev_rdata;
  sample_t             older_rdata;
  sample_t             pc_hold;
  sample_t             pw;
  sample_t             cw0;
  sample_t             cw1;
  acc_t                risk_acc;
  nbr_t                nbr;

  result_t [RESULTS_MAX-1:0] ev_res;
  cnt_t                ev_cnt;
  acc_t                acc_next;
  result_t             head;
  cnt_t                q_cnt;
  logic                pop;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? APB_DATA_BITS'(frame_height)
                                                 : APB_DATA_BITS'(frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        frame_width <= pwdata[CFG_BITS-1:0];
      end else begin
        frame_height <= pwdata[CFG_BITS-1:0];
      end
    end
  end

  // effective frame size: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (HW'(frame_height) > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  // raster position of the next sample
  assign col_inc  = (WW+1)'(col_count) + (WW+1)'(1);
  assign row_inc  = (HW+1)'(row_count) + (HW+1)'(1);
  assign last_col = col_inc >= (WW+1)'(w_eff);
  assign last_row = row_inc >= (HW+1)'(h_eff);
  assign col_next = last_col ? '0 : CW'(col_inc);
  assign row_next = last_row ? '0 : RW'(row_inc);

  assign pos_in.first_row  = (row_count == '0);
  assign pos_in.upper_rows = (RW+1)'(row_count) < (RW+1)'(2);
  assign pos_in.first_col  = (col_count == '0);
  assign pos_in.lead_cols  = (CW+1)'(col_count) < (CW+1)'(2);
  assign pos_in.last_col   = last_col;
  assign pos_in.last_row   = last_row;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_count <= '0;
      row_count <= '0;
    end else if (s_fire) begin
      col_count <= col_next;
      if (last_col) begin
        row_count <= row_next;
      end
    end
  end

  // input handshake and evaluate register
  assign s_fire   = s_tvalid && s_tready;
  assign s1_go    = s1_valid && ((q_cnt == '0) || ((q_cnt == CNT_BITS'(1)) && m_tready));
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_sample <= s_tdata[SAMPLE_BITS-1:0];
      s1_cidx   <= col_count;
      s1_col    <= COORD_BITS'(col_count);
      s1_row    <= COORD_BITS'(row_count);
      s1_pos    <= pos_in;
    end
  end

  // line buffers: previous row read one column ahead, older row in place
  glmrs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_prev_row (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_cidx),
    .wdata (s1_sample),
    .re    (s_fire),
    .raddr (col_next),
    .rdata (prev_rdata)
  );

  glmrs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_older_row (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_cidx),
    .wdata (pc_hold),
    .re    (s_fire),
    .raddr (col_count),
    .rdata (older_rdata)
  );

  // sliding windows; a one-column frame reads back its own sample
  always_ff @(posedge clk) begin
    if (rst) begin
      pc_hold <= '0;
      pw      <= '0;
      cw0     <= '0;
      cw1     <= '0;
    end else if (s1_go) begin
      pc_hold <= (s1_pos.first_col && s1_pos.last_col) ? s1_sample : prev_rdata;
      pw      <= pc_hold;
      cw1     <= cw0;
      cw0     <= s1_sample;
    end
  end

  // frame risk sum
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      risk_acc <= '0;
    end else if (s1_go) begin
      risk_acc <= acc_next;
    end
  end

  assign nbr.north     = older_rdata;
  assign nbr.west      = pw;
  assign nbr.centre_up = pc_hold;
  assign nbr.east      = prev_rdata;
  assign nbr.cur0      = cw0;
  assign nbr.cur1      = cw1;

  glmrs_eval u_eval (
    .sample   (s1_sample),
    .col      (s1_col),
    .row      (s1_row),
    .pos      (s1_pos),
    .nbr      (nbr),
    .acc      (risk_acc),
    .res      (ev_res),
    .cnt      (ev_cnt),
    .acc_next (acc_next)
  );

  // result queue and output word
  assign pop = m_tvalid && m_tready;

  glmrs_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_go),
    .load_cnt (ev_cnt),
    .load_res (ev_res),
    .pop      (pop),
    .head     (head),
    .cnt      (q_cnt)
  );

  assign m_tvalid = (q_cnt != '0);
  assign m_tdata  = {1'b0, head.risk_total, head.risk, head.is_low,
                     head.cell_row, head.cell_col};
  assign m_tlast  = head.last_of_item;
  assign m_tuser  = head.frame_done;

endmodule

`default_nettype wire

// ----- rtl/core/glmrs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "grid_local_minimum_risk_sum_defines.svh"

module glmrs_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [glmrs_pkg::M_DATA_BITS-1:0] m_tdata,
  input wire logic                              m_tlast,
  input wire logic                              m_tuser
);

  import glmrs_pkg::*;

  logic  out_low;
  risk_t out_risk;
  logic  risk_ok;

  assign out_low  = m_tdata[2*COORD_BITS];
  assign out_risk = m_tdata[2*COORD_BITS+RISK_BITS:2*COORD_BITS+1];
  assign risk_ok  = (out_low == (out_risk != '0)) && (out_risk <= RISK_BITS'(16));

  // a pending word is not withdrawn
  `GLMRS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word withdrawn")

  // the frame's final cell is always the last word of its sample
  `GLMRS_ASSERT_IMP(a_done_last, m_tvalid && m_tuser, m_tlast, "frame end not last of item")

  // risk is nonzero exactly for low cells and never above sample range plus one
  `GLMRS_ASSERT_IMP(a_risk_low, m_tvalid, risk_ok, "risk does not match low flag")

  // with no result pending the input side is open
  `GLMRS_ASSERT_IMP(a_idle_ready, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind grid_local_minimum_risk_sum glmrs_checker u_glmrs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
